[hw/rtl/sfr_pkg.sv]
// ----------------------------------------------------------------------------
// Stream find-and-replace package
// Shared constants, register indexes and types for the find-and-replace block.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int PATTERN_MAX     = 8;
  localparam int REPLACEMENT_MAX = 16;

  localparam int BYTE_W     = 8;
  localparam int PAT_LEN_W  = 4;
  localparam int REP_LEN_W  = 5;
  localparam int HELD_W     = 4;
  localparam int PAT_IDX_W  = 3;
  localparam int REP_IDX_W  = 4;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LOW    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_HIGH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 3'd4;

  typedef enum logic [0:0] {
    SRC_HELD        = 1'b0,
    SRC_REPLACEMENT = 1'b1
  } src_t;

  typedef struct packed {
    logic [PATTERN_MAX*BYTE_W-1:0]     pattern_bytes;
    logic [PAT_LEN_W-1:0]              pattern_length;
    logic [REPLACEMENT_MAX*BYTE_W-1:0] replacement;
    logic [REP_LEN_W-1:0]              replacement_length;
  } cfg_t;

  typedef struct packed {
    src_t                 src;
    logic [REP_LEN_W-1:0] cnt;
    logic [PAT_IDX_W-1:0] held;
    logic [BYTE_W-1:0]    text_byte;
    logic                 text_end;
  } desc_t;

endpackage

[hw/rtl/sfr_step.sv]
// ----------------------------------------------------------------------------
// Find-and-replace step logic
// Works out, for one text item, which bytes it releases and the new held count.
// ----------------------------------------------------------------------------
module sfr_step (
  input  sfr_pkg::cfg_t                    cfg,
  input  logic [sfr_pkg::BYTE_W-1:0]       text_byte,
  input  logic                             byte_present,
  input  logic                             text_end,
  input  logic [sfr_pkg::HELD_W-1:0]       held_count,
  output sfr_pkg::desc_t                   desc,
  output logic [sfr_pkg::HELD_W-1:0]       held_nxt
);

  logic [sfr_pkg::PAT_LEN_W-1:0] plen;
  logic [sfr_pkg::REP_LEN_W-1:0] rlen;
  logic [sfr_pkg::PAT_IDX_W-1:0] k;
  logic [sfr_pkg::HELD_W-1:0]    kp;
  logic [sfr_pkg::BYTE_W-1:0]    pat_k;
  logic [sfr_pkg::PATTERN_MAX-1:0] shift_ok;
  logic [sfr_pkg::HELD_W-1:0]    shift;
  logic [sfr_pkg::BYTE_W-1:0]    buf_byte;

  always_comb begin
    plen = (cfg.pattern_length > sfr_pkg::PAT_LEN_W'(sfr_pkg::PATTERN_MAX)) ?
           sfr_pkg::PAT_LEN_W'(sfr_pkg::PATTERN_MAX) : cfg.pattern_length;
    rlen = (cfg.replacement_length > sfr_pkg::REP_LEN_W'(sfr_pkg::REPLACEMENT_MAX)) ?
           sfr_pkg::REP_LEN_W'(sfr_pkg::REPLACEMENT_MAX) : cfg.replacement_length;
    k = ((plen == '0) || (held_count >= plen)) ? '0 : held_count[sfr_pkg::PAT_IDX_W-1:0];
    kp = {1'b0, k} + sfr_pkg::HELD_W'(1);
    pat_k = cfg.pattern_bytes[{k, 3'b000} +: sfr_pkg::BYTE_W];
  end

  // A shift is usable when the bytes it leaves behind form a pattern prefix.
  always_comb begin
    buf_byte = '0;
    for (int s = 1; s <= sfr_pkg::PATTERN_MAX; s++) begin
      shift_ok[s-1] = (s <= int'(k) + 1);
      for (int i = 0; i < sfr_pkg::PATTERN_MAX - s; i++) begin
        if (s + i <= int'(k)) begin
          buf_byte = (s + i < int'(k)) ?
                     cfg.pattern_bytes[(s + i) * sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W] :
                     text_byte;
          if (buf_byte != cfg.pattern_bytes[i * sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W]) begin
            shift_ok[s-1] = 1'b0;
          end
        end
      end
    end
  end

  always_comb begin
    shift = sfr_pkg::HELD_W'(sfr_pkg::PATTERN_MAX);
    for (int s = sfr_pkg::PATTERN_MAX; s >= 1; s--) begin
      if (shift_ok[s-1]) begin
        shift = sfr_pkg::HELD_W'(s);
      end
    end
  end

  always_comb begin
    desc.src       = sfr_pkg::SRC_HELD;
    desc.cnt       = '0;
    desc.held      = k;
    desc.text_byte = text_byte;
    desc.text_end  = text_end;
    held_nxt       = {1'b0, k};
    if (byte_present) begin
      if (plen == '0) begin
        desc.held = '0;
        desc.cnt  = sfr_pkg::REP_LEN_W'(1);
        held_nxt  = '0;
      end else if (pat_k == text_byte) begin
        if (kp == plen) begin
          desc.src = sfr_pkg::SRC_REPLACEMENT;
          desc.cnt = rlen;
          held_nxt = '0;
        end else if (text_end) begin
          desc.cnt = {1'b0, kp};
          held_nxt = '0;
        end else begin
          held_nxt = kp;
        end
      end else if (text_end) begin
        desc.cnt = {1'b0, kp};
        held_nxt = '0;
      end else begin
        desc.cnt = {1'b0, shift};
        held_nxt = kp - shift;
      end
    end else if (text_end) begin
      desc.cnt = {2'b00, k};
      held_nxt = '0;
    end
  end

endmodule

[hw/rtl/sfr_emit.sv]
// ----------------------------------------------------------------------------
// Find-and-replace result emitter
// Holds one released run and sends its bytes one result transaction per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module sfr_emit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sfr_pkg::cfg_t                cfg,
  input  logic                         load,
  input  sfr_pkg::desc_t               desc,
  output logic                         free,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [sfr_pkg::BYTE_W-1:0]   out_byte,
  output logic                         out_present,
  output logic                         out_run_last,
  output logic                         out_text_end
);

  logic                             valid_r;
  logic                             valid_nxt;
  sfr_pkg::desc_t                   desc_r;
  sfr_pkg::desc_t                   desc_nxt;
  logic [sfr_pkg::REP_IDX_W-1:0]    idx_r;
  logic [sfr_pkg::REP_IDX_W-1:0]    idx_nxt;
  logic                             last;

  always_comb begin
    last = (desc_r.cnt == '0) || ({1'b0, idx_r} == desc_r.cnt - sfr_pkg::REP_LEN_W'(1));
    free = !valid_r || (!out_stall && last);
    valid_nxt = valid_r;
    desc_nxt  = desc_r;
    idx_nxt   = idx_r;
    if (load) begin
      valid_nxt = 1'b1;
      desc_nxt  = desc;
      idx_nxt   = '0;
    end else if (valid_r && !out_stall) begin
      if (last) begin
        valid_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + sfr_pkg::REP_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    desc_r <= desc_nxt;
    idx_r  <= idx_nxt;
  end

  always_comb begin
    out_valid    = valid_r;
    out_present  = (desc_r.cnt != '0);
    out_run_last = last;
    out_text_end = last && desc_r.text_end;
    out_byte     = '0;
    if (desc_r.cnt != '0) begin
      case (desc_r.src)
        sfr_pkg::SRC_REPLACEMENT: begin
          out_byte = cfg.replacement[{idx_r, 3'b000} +: sfr_pkg::BYTE_W];
        end
        sfr_pkg::SRC_HELD: begin
          out_byte = (idx_r < {1'b0, desc_r.held}) ?
                     cfg.pattern_bytes[{idx_r[sfr_pkg::PAT_IDX_W-1:0], 3'b000}
                                       +: sfr_pkg::BYTE_W] :
                     desc_r.text_byte;
        end
        default: begin
          out_byte = '0;
        end
      endcase
    end
  end

endmodule

[hw/rtl/stream_find_replace.sv]
// ----------------------------------------------------------------------------
// Stream find-and-replace
// Rewrites a byte stream, replacing every leftmost non-overlapping occurrence
// of a configured pattern with a configured replacement string.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake            Carries
//   in_       input      in_valid/in_stall    text byte, byte present, text end
//   out_      output     out_valid/out_stall  byte, present, run last, text end
//   cfg_      input      cfg_we               register index and write data
//
// An accepted transaction lands in an input register and is resolved from there
// into the emitter's register, which offers its first result. The emitter
// sends one result per cycle while out_stall is low; an item that releases
// nothing and does not end the text gives no result. Reset clears the held
// count, the configuration and both valid flags.
// A stalled output keeps its payload and backs up into in_stall.
// ----------------------------------------------------------------------------
module stream_find_replace (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [sfr_pkg::BYTE_W-1:0]      in_text_byte,
  input  logic                            in_byte_present,
  input  logic                            in_text_end,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [sfr_pkg::BYTE_W-1:0]      out_byte,
  output logic                            out_present,
  output logic                            out_run_last,
  output logic                            out_text_end,
  input  logic                            cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  sfr_pkg::cfg_t                   cfg_r;
  logic                            in_valid_r;
  logic                            in_valid_nxt;
  logic [sfr_pkg::BYTE_W-1:0]      text_byte_r;
  logic                            byte_present_r;
  logic                            text_end_r;
  logic [sfr_pkg::HELD_W-1:0]      held_count_r;
  logic [sfr_pkg::HELD_W-1:0]      held_count_nxt;
  logic [sfr_pkg::HELD_W-1:0]      step_held;
  sfr_pkg::desc_t                  step_desc;
  logic                            silent;
  logic                            emit_free;
  logic                            advance;
  logic                            accept;
  logic                            pattern_write;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sfr_pkg::REG_PATTERN_BYTES: begin
          cfg_r.pattern_bytes <= cfg_data;
        end
        sfr_pkg::REG_PATTERN_LENGTH: begin
          cfg_r.pattern_length <= cfg_data[sfr_pkg::PAT_LEN_W-1:0];
        end
        sfr_pkg::REG_REPLACEMENT_LOW: begin
          cfg_r.replacement[sfr_pkg::CFG_DATA_W-1:0] <= cfg_data;
        end
        sfr_pkg::REG_REPLACEMENT_HIGH: begin
          cfg_r.replacement[2*sfr_pkg::CFG_DATA_W-1:sfr_pkg::CFG_DATA_W] <= cfg_data;
        end
        sfr_pkg::REG_REPLACEMENT_LENGTH: begin
          cfg_r.replacement_length <= cfg_data[sfr_pkg::REP_LEN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  sfr_step u_step (
    .cfg          (cfg_r),
    .text_byte    (text_byte_r),
    .byte_present (byte_present_r),
    .text_end     (text_end_r),
    .held_count   (held_count_r),
    .desc         (step_desc),
    .held_nxt     (step_held)
  );

  always_comb begin
    silent        = (step_desc.cnt == '0) && !step_desc.text_end;
    advance       = in_valid_r && (silent || emit_free);
    in_stall      = in_valid_r && !advance;
    accept        = in_valid && !in_stall;
    pattern_write = cfg_we && ((cfg_index == sfr_pkg::REG_PATTERN_BYTES) ||
                               (cfg_index == sfr_pkg::REG_PATTERN_LENGTH));
    in_valid_nxt  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_r);
    held_count_nxt = held_count_r;
    if (pattern_write) begin
      held_count_nxt = '0;
    end else if (advance) begin
      held_count_nxt = step_held;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      held_count_r <= '0;
    end else begin
      in_valid_r   <= in_valid_nxt;
      held_count_r <= held_count_nxt;
    end
    if (accept) begin
      text_byte_r    <= in_text_byte;
      byte_present_r <= in_byte_present;
      text_end_r     <= in_text_end;
    end
  end

  sfr_emit u_emit (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .load         (advance && !silent),
    .desc         (step_desc),
    .free         (emit_free),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_present  (out_present),
    .out_run_last (out_run_last),
    .out_text_end (out_text_end)
  );

  a_end_clears_held: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && text_end_r) |=> (held_count_r == '0))
    else $error("held count not cleared after end of text");

  a_pattern_write_clears: assert property (@(posedge clk) disable iff (!rst_n)
    pattern_write |=> (held_count_r == '0))
    else $error("pattern write did not clear held count");

  a_empty_is_closing: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_present) |-> (out_text_end && out_run_last))
    else $error("empty result that is not a closing result");

  a_text_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_text_end) |-> out_run_last)
    else $error("end of text flagged before the last result of its run");

endmodule
